// ===== hdl/otsu_histogram_threshold_macros.svh =====
// Assertion macros shared by the Otsu threshold modules.
`ifndef OTSU_HISTOGRAM_THRESHOLD_MACROS_SVH
`define OTSU_HISTOGRAM_THRESHOLD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OTSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("otsu threshold: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OTSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("otsu threshold: next-cycle check failed");

`endif

// ===== hdl/otsu_pkg.sv =====
package otsu_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_BINS   = 256;
  localparam int DEF_COUNT_BITS = 16;

  // Fixed port widths.
  localparam int IN_COUNT_W = 16;
  localparam int THR_W      = 8;

  // Multiplier digit width: one digit of the second operand per cycle.
  localparam int DIGIT_W = 16;

  // Controller states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_TEST,
    ST_READ,
    ST_ACC,
    ST_CHECK,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_Q,
    ST_MUL_SQ,
    ST_MUL_RHS,
    ST_MUL_LHS,
    ST_POST
  } state_t;

  // Multiplier operations: which operands go in, where the product goes.
  typedef enum logic [2:0] {
    MOP_A,    // total weighted sum times running count
    MOP_B,    // running weighted sum times total count
    MOP_Q,    // running count times remaining count
    MOP_SQ,   // difference squared
    MOP_RHS,  // best squared difference times current denominator
    MOP_LHS   // current squared difference times best denominator
  } mop_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // store the incoming bin and update totals
    logic clear;      // return histogram state to its reset values
    logic rd;         // read the bin at the scan position
    logic acc;        // add the read bin into the running sums
    logic mul_start;  // start a multiplication
    mop_t start_op;
    logic cap;        // capture the finished product
    mop_t cap_op;
    logic diff;       // form the absolute difference from the B product
    logic cmp;        // compare scores and update the best bin
    logic next;       // advance the scan position
    logic post;       // load the result register
  } ctrl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic mul_done;
    logic skip;       // cumulative share is zero or all
    logic scan_more;  // another bin remains to be scanned
    logic ovf_now;    // this histogram has too many bins
    logic out_busy;   // result register still holds an untaken item
  } dp_stat_t;

endpackage

// ===== hdl/otsu_mul.sv =====
`include "otsu_histogram_threshold_macros.svh"

module otsu_mul #(
  parameter int A_W  = 56,
  parameter int B_W  = 112,
  parameter int ND_W = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  input  logic [ND_W-1:0]    ndig,
  output logic               done,
  output logic [A_W+B_W-1:0] p
);

  localparam int P_W = A_W + B_W;
  localparam int D_W = otsu_pkg::DIGIT_W;

  logic [A_W-1:0]     a_r;
  logic [B_W-1:0]     b_r, b_nxt;
  logic [P_W-1:0]     acc_r, acc_nxt;
  logic [ND_W-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [D_W-1:0]     digit;
  logic [A_W+D_W-1:0] pp;

  // Take the top digit of the left-aligned operand each cycle.
  assign digit = b_r[B_W-1 -: D_W];
  assign pp    = {{D_W{1'b0}}, a_r} * {{A_W{1'b0}}, digit};
  assign done  = busy_r && (cnt_r == '0);
  assign p     = acc_r;

  always_comb begin
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt  = '0;
      b_nxt    = b;
      cnt_nxt  = ndig;
      busy_nxt = 1'b1;
    end else begin
      if (cnt_r != '0) begin
        // Shift and add one partial product.
        acc_nxt = (acc_r << D_W) + P_W'(pp);
        b_nxt   = b_r << D_W;
        cnt_nxt = cnt_r - 1'b1;
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Hold control state under reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Advance operands and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
    end
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  `OTSU_ASSERT_NOW(a_start_idle, clk, rst_n, start, cnt_r == '0)

endmodule

// ===== hdl/otsu_dpath.sv =====
`include "otsu_histogram_threshold_macros.svh"

module otsu_dpath #(
  parameter int MAX_BINS   = otsu_pkg::DEF_MAX_BINS,
  parameter int COUNT_BITS = otsu_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  otsu_pkg::ctrl_cmd_t             cmd,
  output otsu_pkg::dp_stat_t              stat,
  input  logic [otsu_pkg::IN_COUNT_W-1:0] in_bin_count,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [otsu_pkg::THR_W-1:0]      out_threshold,
  output logic                            out_too_many_bins
);

  localparam int DIG    = otsu_pkg::DIGIT_W;
  localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int TOT_W  = COUNT_BITS + IDX_W;
  localparam int WS_W   = COUNT_BITS + 2 * IDX_W;
  localparam int D_W    = WS_W + TOT_W;
  localparam int Q_W    = 2 * TOT_W;
  localparam int SQ_W   = 2 * D_W;
  localparam int CMP_W  = SQ_W + Q_W;
  localparam int ND_TOT = (TOT_W + DIG - 1) / DIG;
  localparam int ND_D   = (D_W + DIG - 1) / DIG;
  localparam int ND_SQ  = (SQ_W + DIG - 1) / DIG;
  localparam int BB_W   = ND_SQ * DIG;
  localparam int SH_TOT = BB_W - ND_TOT * DIG;
  localparam int SH_D   = BB_W - ND_D * DIG;
  localparam int ND_W   = $clog2(ND_SQ + 1);
  localparam int P_W    = D_W + BB_W;

  // Bin store: written while loading, read while scanning.
  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic [COUNT_BITS-1:0] rd_data_r;

  logic [CNT_W-1:0] bins_seen_r;
  logic             overflow_r;
  logic [TOT_W-1:0] total_r;
  logic [WS_W-1:0]  wtotal_r;
  logic [TOT_W-1:0] run_cnt_r;
  logic [WS_W-1:0]  run_w_r;
  logic [SQ_W-1:0]  best_sq_r;
  logic [Q_W-1:0]   best_q_r;
  logic [IDX_W-1:0] best_bin_r;
  logic [IDX_W-1:0] scan_pos_r;

  logic [D_W-1:0]   pa_r;
  logic [D_W-1:0]   d_r;
  logic [Q_W-1:0]   q_r;
  logic [SQ_W-1:0]  dsq_r;
  logic [CMP_W-1:0] rhs_r;

  logic                  out_valid_r;
  logic [otsu_pkg::THR_W-1:0] out_thr_r;
  logic                  out_tmb_r;

  logic [COUNT_BITS-1:0] cnt_in;
  logic                  full;
  logic [D_W-1:0]        pb;
  logic [CMP_W-1:0]      lhs;
  logic                  gt;

  logic [D_W-1:0]  mul_a;
  logic [BB_W-1:0] mul_b;
  logic [ND_W-1:0] mul_nd;
  logic            mul_done;
  logic [P_W-1:0]  mul_p;

  assign cnt_in = COUNT_BITS'(in_bin_count);
  assign full   = (bins_seen_r == CNT_W'(MAX_BINS));
  assign pb     = mul_p[D_W-1:0];
  assign lhs    = mul_p[CMP_W-1:0];
  assign gt     = lhs > rhs_r;

  // Status to the controller.
  always_comb begin
    stat.mul_done  = mul_done;
    stat.skip      = (run_cnt_r == '0) || (run_cnt_r == total_r);
    stat.scan_more = (CNT_W'(scan_pos_r) + 1'b1) < bins_seen_r;
    stat.ovf_now   = overflow_r || full;
    stat.out_busy  = out_valid_r && out_stall;
  end

  // Select multiplier operands; the second one is left-aligned on digits.
  always_comb begin
    case (cmd.start_op)
      otsu_pkg::MOP_A: begin
        mul_a  = D_W'(wtotal_r);
        mul_b  = BB_W'(run_cnt_r) << SH_TOT;
        mul_nd = ND_W'(ND_TOT);
      end
      otsu_pkg::MOP_B: begin
        mul_a  = D_W'(run_w_r);
        mul_b  = BB_W'(total_r) << SH_TOT;
        mul_nd = ND_W'(ND_TOT);
      end
      otsu_pkg::MOP_Q: begin
        mul_a  = D_W'(run_cnt_r);
        mul_b  = BB_W'(total_r - run_cnt_r) << SH_TOT;
        mul_nd = ND_W'(ND_TOT);
      end
      otsu_pkg::MOP_SQ: begin
        mul_a  = d_r;
        mul_b  = BB_W'(d_r) << SH_D;
        mul_nd = ND_W'(ND_D);
      end
      otsu_pkg::MOP_RHS: begin
        mul_a  = D_W'(q_r);
        mul_b  = BB_W'(best_sq_r);
        mul_nd = ND_W'(ND_SQ);
      end
      otsu_pkg::MOP_LHS: begin
        mul_a  = D_W'(best_q_r);
        mul_b  = BB_W'(dsq_r);
        mul_nd = ND_W'(ND_SQ);
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_nd = ND_W'(ND_TOT);
      end
    endcase
  end

  otsu_mul #(
    .A_W  (D_W),
    .B_W  (BB_W),
    .ND_W (ND_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .ndig  (mul_nd),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Write the bin store.
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[bins_seen_r[IDX_W-1:0]] <= cnt_in;
    end
  end

  // Read the bin store.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[scan_pos_r];
    end
  end

  // Histogram totals, running sums and best score.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      bins_seen_r <= '0;
      overflow_r  <= 1'b0;
      total_r     <= '0;
      wtotal_r    <= '0;
      run_cnt_r   <= '0;
      run_w_r     <= '0;
      best_sq_r   <= '0;
      best_q_r    <= Q_W'(1);
      best_bin_r  <= '0;
      scan_pos_r  <= '0;
    end else begin
      if (cmd.load) begin
        if (full) begin
          overflow_r <= 1'b1;
        end else begin
          bins_seen_r <= bins_seen_r + 1'b1;
          total_r     <= total_r + TOT_W'(cnt_in);
          wtotal_r    <= wtotal_r
                         + WS_W'(cnt_in) * WS_W'(bins_seen_r[IDX_W-1:0]);
        end
      end
      if (cmd.acc) begin
        run_cnt_r <= run_cnt_r + TOT_W'(rd_data_r);
        run_w_r   <= run_w_r + WS_W'(rd_data_r) * WS_W'(scan_pos_r);
      end
      if (cmd.cmp && gt) begin
        best_sq_r  <= dsq_r;
        best_q_r   <= q_r;
        best_bin_r <= scan_pos_r;
      end
      if (cmd.next) begin
        scan_pos_r <= scan_pos_r + 1'b1;
      end
    end
  end

  // Capture products and the absolute difference.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      case (cmd.cap_op)
        otsu_pkg::MOP_A:   pa_r  <= mul_p[D_W-1:0];
        otsu_pkg::MOP_Q:   q_r   <= mul_p[Q_W-1:0];
        otsu_pkg::MOP_SQ:  dsq_r <= mul_p[SQ_W-1:0];
        otsu_pkg::MOP_RHS: rhs_r <= mul_p[CMP_W-1:0];
        default: ;
      endcase
    end
    if (cmd.diff) begin
      d_r <= (pa_r >= pb) ? (pa_r - pb) : (pb - pa_r);
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.post || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_thr_r <= otsu_pkg::THR_W'(best_bin_r);
      out_tmb_r <= overflow_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_threshold     = out_thr_r;
  assign out_too_many_bins = out_tmb_r;

  `OTSU_ASSERT_NOW(a_rise_on_post, clk, rst_n, $rose(out_valid_r), $past(cmd.post))
  `OTSU_ASSERT_NEXT(a_best_update, clk, rst_n, cmd.cmp && gt && !cmd.clear, best_bin_r == $past(scan_pos_r))

endmodule

// ===== hdl/otsu_ctrl.sv =====
`include "otsu_histogram_threshold_macros.svh"

module otsu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_bin,
  output logic                in_stall,
  output otsu_pkg::ctrl_cmd_t cmd,
  input  otsu_pkg::dp_stat_t  stat
);

  otsu_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= otsu_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      otsu_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_bin) begin
            state_nxt = stat.ovf_now ? otsu_pkg::ST_POST : otsu_pkg::ST_TEST;
          end
        end
      end
      otsu_pkg::ST_TEST: begin
        state_nxt = stat.scan_more ? otsu_pkg::ST_READ : otsu_pkg::ST_POST;
      end
      otsu_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = otsu_pkg::ST_ACC;
      end
      otsu_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = otsu_pkg::ST_CHECK;
      end
      otsu_pkg::ST_CHECK: begin
        // Drop bins whose share is zero or all.
        if (stat.skip) begin
          cmd.next  = 1'b1;
          state_nxt = otsu_pkg::ST_TEST;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.start_op  = otsu_pkg::MOP_A;
          state_nxt     = otsu_pkg::ST_MUL_A;
        end
      end
      otsu_pkg::ST_MUL_A: begin
        if (stat.mul_done) begin
          cmd.cap       = 1'b1;
          cmd.cap_op    = otsu_pkg::MOP_A;
          cmd.mul_start = 1'b1;
          cmd.start_op  = otsu_pkg::MOP_B;
          state_nxt     = otsu_pkg::ST_MUL_B;
        end
      end
      otsu_pkg::ST_MUL_B: begin
        if (stat.mul_done) begin
          cmd.diff      = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.start_op  = otsu_pkg::MOP_Q;
          state_nxt     = otsu_pkg::ST_MUL_Q;
        end
      end
      otsu_pkg::ST_MUL_Q: begin
        if (stat.mul_done) begin
          cmd.cap       = 1'b1;
          cmd.cap_op    = otsu_pkg::MOP_Q;
          cmd.mul_start = 1'b1;
          cmd.start_op  = otsu_pkg::MOP_SQ;
          state_nxt     = otsu_pkg::ST_MUL_SQ;
        end
      end
      otsu_pkg::ST_MUL_SQ: begin
        if (stat.mul_done) begin
          cmd.cap       = 1'b1;
          cmd.cap_op    = otsu_pkg::MOP_SQ;
          cmd.mul_start = 1'b1;
          cmd.start_op  = otsu_pkg::MOP_RHS;
          state_nxt     = otsu_pkg::ST_MUL_RHS;
        end
      end
      otsu_pkg::ST_MUL_RHS: begin
        if (stat.mul_done) begin
          cmd.cap       = 1'b1;
          cmd.cap_op    = otsu_pkg::MOP_RHS;
          cmd.mul_start = 1'b1;
          cmd.start_op  = otsu_pkg::MOP_LHS;
          state_nxt     = otsu_pkg::ST_MUL_LHS;
        end
      end
      otsu_pkg::ST_MUL_LHS: begin
        if (stat.mul_done) begin
          cmd.cmp   = 1'b1;
          cmd.next  = 1'b1;
          state_nxt = otsu_pkg::ST_TEST;
        end
      end
      otsu_pkg::ST_POST: begin
        // Wait for the result register, then clear for the next histogram.
        if (!stat.out_busy) begin
          cmd.post  = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = otsu_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = otsu_pkg::ST_LOAD;
      end
    endcase
  end

  `OTSU_ASSERT_NEXT(a_stall_after_last, clk, rst_n, in_valid && !in_stall && in_last_bin, in_stall)

endmodule

// ===== hdl/otsu_histogram_threshold.sv =====
// Loading: one bin item per cycle, no result for items that are not last.
// After the last bin, every bin except the final one is scanned (the scan is skipped if the
// histogram has too many bins); a bin whose cumulative share is zero or all needs no products,
// else the 16-bit digit-serial multiplier forms six products for it, then the result is posted.
// Results wait in an output register while the next histogram loads.
// Reset (rst_n low, synchronous) clears the controller and totals; the bin store is not cleared.
module otsu_histogram_threshold #(
  parameter int MAX_BINS   = otsu_pkg::DEF_MAX_BINS,
  parameter int COUNT_BITS = otsu_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [otsu_pkg::IN_COUNT_W-1:0] in_bin_count,
  input  logic                            in_last_bin,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [otsu_pkg::THR_W-1:0]      out_threshold,
  output logic                            out_too_many_bins
);

  otsu_pkg::ctrl_cmd_t cmd;
  otsu_pkg::dp_stat_t  stat;

  otsu_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_bin (in_last_bin),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  otsu_dpath #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_bin_count      (in_bin_count),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_threshold     (out_threshold),
    .out_too_many_bins (out_too_many_bins)
  );

endmodule
